// ----- hw/rtl/integer_to_ascii_formatter_core_macros.svh -----
// Assertion macros for the integer-to-ASCII formatter.
// No dependencies; included by the top level.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication.
`define IAF_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication.
`define IAF_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- hw/rtl/iaf_pkg.sv -----
// Package for the integer-to-ASCII formatter: sizes, radix codes, ASCII
// constants, digit table and the sequencer state type. No dependencies.
`default_nettype none

package iaf_pkg;

   localparam int MAX_FIELD   = 60;   // width and precision saturate here
   localparam int VALUE_BITS  = 32;
   localparam int DIGIT_SLOTS = 12;   // nibble slots in the digit register
   localparam int OCT_DIGITS  = 11;   // octal digits of a 32-bit value

   localparam logic [1:0] RADIX_OCT = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;

   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_X     = 8'h58;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;
   localparam logic [7:0] ASCII_PLUS  = 8'h2B;
   localparam logic [7:0] CASE_BIT    = 8'h20;

   localparam logic [7:0] DIGIT_CHARS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_NORM,
      ST_LAYOUT,
      ST_LEAD,
      ST_SIGN,
      ST_PFX0,
      ST_PFXX,
      ST_ZERO,
      ST_PREC,
      ST_DIGIT,
      ST_TRAIL
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/integer_to_ascii_formatter_core.sv -----
// Integer-to-ASCII formatter top level: digit conversion and character sequencer.
// Depends on iaf_pkg and integer_to_ascii_formatter_core_macros.svh.
//
//   channel   ports                           handshake
//   -------   -----------------------------   ------------------------------------
//   request   req_* fields                    taken when start && !busy
//   result    rsp_char_code, rsp_last         one cycle, rsp_valid strobe, no stall
//
// Steps per word: load, bit-serial double-dabble BCD conversion (decimal only),
// normalize (leading zero digits dropped), layout, then lead pad, 3 sign/prefix
// slots used or not, zero pad, precision zeros, digits and trail pad; each empty
// pad phase (2 to 4) is still visited. One character per cycle while a phase emits.
// Synchronous active-high reset returns the sequencer to idle and drops the strobe.
// No stall on the result side; busy stays high until the last character is on the ports.
`default_nettype none

`include "integer_to_ascii_formatter_core_macros.svh"

module integer_to_ascii_formatter_core
   import iaf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire logic [1:0]            req_radix_select,
   input  wire logic [5:0]            req_field_width,
   input  wire logic [5:0]            req_min_digits,
   input  wire logic                  req_zero_pad,
   input  wire logic                  req_signed_mode,
   input  wire logic                  req_show_plus,
   input  wire logic                  req_space_sign,
   input  wire logic                  req_left_justify,
   input  wire logic                  req_lower_case,
   input  wire logic                  req_alt_prefix,
   output      logic                  rsp_valid,
   output      logic [7:0]            rsp_char_code,
   output      logic                  rsp_last
);

   localparam int         DigW     = DIGIT_SLOTS * 4;
   localparam logic [5:0] MaxField = 6'(MAX_FIELD);

   state_type state_ff, state_in;

   // digit register: nibble slots, slot 0 is the least significant digit
   logic [DigW-1:0]       digit_ff, digit_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;       // magnitude shifted out MSB first
   logic [4:0]            bit_cnt_ff, bit_cnt_in;
   logic [3:0]            nd_ff, nd_in;         // digits left to show
   logic [5:0]            width_ff, width_in;
   logic [5:0]            prec_ff, prec_in;
   logic [5:0]            rest_ff, rest_in;     // padding characters left
   logic [5:0]            precz_ff, precz_in;   // precision zeros left
   logic [5:0]            remain_ff, remain_in; // characters left in this word
   logic                  sign_en_ff, sign_en_in;
   logic [7:0]            sign_char_ff, sign_char_in;
   logic                  pfx0_ff, pfx0_in;
   logic                  pfxx_ff, pfxx_in;
   logic                  zpad_ff, zpad_in;
   logic                  left_ff, left_in;
   logic                  lc_ff, lc_in;

   logic                  rsp_valid_ff;
   logic [7:0]            rsp_char_ff;
   logic                  rsp_last_ff;

   logic                  emit;
   logic [7:0]            emit_char;

   // request decode
   logic                  neg;
   logic [VALUE_BITS-1:0] mag;
   logic [VALUE_BITS:0]   oct_ext;
   logic [DigW-1:0]       oct_nibbles;
   logic [DigW-1:0]       dd_adj;

   // layout arithmetic
   logic [5:0]            prec_eff;
   logic [6:0]            used;
   logic                  width_wins;
   logic [5:0]            rest_calc;
   logic [5:0]            total_calc;

   // per-phase padding counts; only one of the three is ever nonzero
   logic [5:0]            lead_cnt, zero_cnt, trail_cnt;
   logic [3:0]            top_nib;
   logic [7:0]            case_mask;

   assign busy      = (state_ff != ST_IDLE);
   assign top_nib   = digit_ff[DigW-1 -: 4];
   assign case_mask = lc_ff ? CASE_BIT : 8'h00;

   assign lead_cnt  = (!zpad_ff && !left_ff) ? rest_ff : 6'd0;
   assign zero_cnt  = zpad_ff ? rest_ff : 6'd0;
   assign trail_cnt = left_ff ? rest_ff : 6'd0;

   // two's complement magnitude; the most negative value maps to itself
   assign neg     = req_signed_mode & req_value[VALUE_BITS-1];
   assign mag     = neg ? (VALUE_BITS'(0) - req_value) : req_value;
   assign oct_ext = {1'b0, mag};

   // octal digits are 3-bit groups, widened to nibble slots
   always_comb begin
      oct_nibbles = '0;
      for (int k = 0; k < OCT_DIGITS; k++) begin
         oct_nibbles[4*k +: 4] = {1'b0, oct_ext[3*k +: 3]};
      end
   end

   // double-dabble add-3 on every BCD slot before the shift
   always_comb begin
      logic [3:0] nib;
      dd_adj = '0;
      for (int k = 0; k < DIGIT_SLOTS; k++) begin
         nib = digit_ff[4*k +: 4];
         dd_adj[4*k +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
      end
   end

   // rest = width - sign - prefix - max(precision, nd), floored at zero
   assign prec_eff   = (prec_ff > {2'b00, nd_ff}) ? prec_ff : {2'b00, nd_ff};
   assign used       = 7'(sign_en_ff) + 7'(pfx0_ff) + 7'(pfxx_ff) + {1'b0, prec_eff};
   assign width_wins = ({1'b0, width_ff} > used);
   assign rest_calc  = width_wins ? 6'({1'b0, width_ff} - used) : 6'd0;
   assign total_calc = width_wins ? width_ff : used[5:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_radix_select == RADIX_DEC) ? ST_CONVERT : ST_NORM;
            end
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == 5'd0) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (!(top_nib == 4'd0 && nd_ff > 4'd1)) begin
               state_in = ST_LAYOUT;
            end
         end
         ST_LAYOUT: state_in = ST_LEAD;
         ST_LEAD: begin
            if (lead_cnt <= 6'd1) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: state_in = ST_PFX0;
         ST_PFX0: state_in = ST_PFXX;
         ST_PFXX: state_in = ST_ZERO;
         ST_ZERO: begin
            if (zero_cnt <= 6'd1) begin
               state_in = ST_PREC;
            end
         end
         ST_PREC: begin
            if (precz_ff <= 6'd1) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (nd_ff <= 4'd1) begin
               state_in = ST_TRAIL;
            end
         end
         ST_TRAIL: begin
            if (trail_cnt <= 6'd1) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and character selection
   always_comb begin
      digit_in     = digit_ff;
      bin_in       = bin_ff;
      bit_cnt_in   = bit_cnt_ff;
      nd_in        = nd_ff;
      width_in     = width_ff;
      prec_in      = prec_ff;
      rest_in      = rest_ff;
      precz_in     = precz_ff;
      remain_in    = remain_ff;
      sign_en_in   = sign_en_ff;
      sign_char_in = sign_char_ff;
      pfx0_in      = pfx0_ff;
      pfxx_in      = pfxx_ff;
      zpad_in      = zpad_ff;
      left_in      = left_ff;
      lc_in        = lc_ff;
      emit         = 1'b0;
      emit_char    = ASCII_SPACE;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_radix_select[1]) begin
                  digit_in = {{(DigW-VALUE_BITS){1'b0}}, mag};
               end else if (req_radix_select == RADIX_OCT) begin
                  digit_in = oct_nibbles;
               end else begin
                  digit_in = '0;
               end
               bin_in       = mag;
               bit_cnt_in   = 5'(VALUE_BITS - 1);
               nd_in        = 4'(DIGIT_SLOTS);
               width_in     = (req_field_width > MaxField) ? MaxField : req_field_width;
               prec_in      = (req_min_digits > MaxField) ? MaxField : req_min_digits;
               zpad_in      = req_zero_pad & ~req_left_justify;
               left_in      = req_left_justify;
               lc_in        = req_lower_case;
               sign_en_in   = neg | (req_signed_mode & (req_show_plus | req_space_sign));
               sign_char_in = neg ? ASCII_MINUS : (req_show_plus ? ASCII_PLUS : ASCII_SPACE);
               pfx0_in      = req_alt_prefix &
                              ((req_radix_select == RADIX_OCT) || req_radix_select[1]);
               pfxx_in      = req_alt_prefix & req_radix_select[1];
            end
         end
         ST_CONVERT: begin
            digit_in   = {dd_adj[DigW-2:0], bin_ff[VALUE_BITS-1]};
            bin_in     = {bin_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 5'd1;
         end
         ST_NORM: begin
            // drop leading zero digits, keep at least one
            if (top_nib == 4'd0 && nd_ff > 4'd1) begin
               digit_in = {digit_ff[DigW-5:0], 4'd0};
               nd_in    = nd_ff - 4'd1;
            end
         end
         ST_LAYOUT: begin
            rest_in   = rest_calc;
            precz_in  = prec_eff - {2'b00, nd_ff};
            remain_in = total_calc;
         end
         ST_LEAD: begin
            if (lead_cnt != 6'd0) begin
               emit      = 1'b1;
               emit_char = ASCII_SPACE;
               rest_in   = rest_ff - 6'd1;
            end
         end
         ST_SIGN: begin
            if (sign_en_ff) begin
               emit      = 1'b1;
               emit_char = sign_char_ff;
            end
         end
         ST_PFX0: begin
            if (pfx0_ff) begin
               emit      = 1'b1;
               emit_char = ASCII_ZERO;
            end
         end
         ST_PFXX: begin
            if (pfxx_ff) begin
               emit      = 1'b1;
               emit_char = ASCII_X | case_mask;
            end
         end
         ST_ZERO: begin
            if (zero_cnt != 6'd0) begin
               emit      = 1'b1;
               emit_char = ASCII_ZERO;
               rest_in   = rest_ff - 6'd1;
            end
         end
         ST_PREC: begin
            if (precz_ff != 6'd0) begin
               emit      = 1'b1;
               emit_char = ASCII_ZERO;
               precz_in  = precz_ff - 6'd1;
            end
         end
         ST_DIGIT: begin
            emit      = 1'b1;
            emit_char = DIGIT_CHARS[top_nib] | case_mask;
            digit_in  = {digit_ff[DigW-5:0], 4'd0};
            nd_in     = nd_ff - 4'd1;
         end
         ST_TRAIL: begin
            if (trail_cnt != 6'd0) begin
               emit      = 1'b1;
               emit_char = ASCII_SPACE;
               rest_in   = rest_ff - 6'd1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      if (emit) begin
         remain_in = remain_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff     <= digit_in;
      bin_ff       <= bin_in;
      bit_cnt_ff   <= bit_cnt_in;
      nd_ff        <= nd_in;
      width_ff     <= width_in;
      prec_ff      <= prec_in;
      rest_ff      <= rest_in;
      precz_ff     <= precz_in;
      remain_ff    <= remain_in;
      sign_en_ff   <= sign_en_in;
      sign_char_ff <= sign_char_in;
      pfx0_ff      <= pfx0_in;
      pfxx_ff      <= pfxx_in;
      zpad_ff      <= zpad_in;
      left_ff      <= left_in;
      lc_ff        <= lc_in;
      rsp_char_ff  <= emit_char;
      rsp_last_ff  <= (remain_ff == 6'd1);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
   `IAF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not raise busy")
   `IAF_ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_last, !rsp_valid, "char after last")
   `IAF_ASSERT_NOW(a_idle_last, clock, reset, rsp_valid && !busy, rsp_last, "idle before last")
   `IAF_ASSERT_NOW(a_digit_cnt, clock, reset, state_ff == ST_DIGIT, nd_ff != 4'd0, "no digit left")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for integer_to_ascii_formatter_core.
// Directed and random requests are checked character by character against a local
// formatter model. Depends on iaf_pkg and the core RTL.
`default_nettype none

module tb
   import iaf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The package only names octal and decimal; hex and the spare code are ours.
   localparam logic [1:0] RADIX_HEX  = 2'd2;
   localparam logic [1:0] RADIX_RSVD = 2'd3;   // decodes as hex
   localparam logic [7:0] ASCII_A    = 8'h41;

   // Flag masks for building directed words.
   localparam logic [6:0] FL_NONE  = 7'b0000000;
   localparam logic [6:0] FL_ZPAD  = 7'b1000000;
   localparam logic [6:0] FL_SGN   = 7'b0100000;
   localparam logic [6:0] FL_PLUS  = 7'b0010000;
   localparam logic [6:0] FL_SPC   = 7'b0001000;
   localparam logic [6:0] FL_LEFT  = 7'b0000100;
   localparam logic [6:0] FL_LC    = 7'b0000010;
   localparam logic [6:0] FL_ALT   = 7'b0000001;

   localparam int RANDOM_WORDS  = 480;
   localparam int DRAIN_CYCLES  = 150;   // > worst-case word latency
   // The worst word (load, BCD, normalize, 63 chars) and sender gaps at
   // 74% idle stay well below this limit. Counted only while nothing is accepted.
   localparam int STALL_LIMIT   = 2000;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  radix;
      logic [5:0]  width;
      logic [5:0]  digits;
      logic        zero_pad;
      logic        signed_mode;
      logic        show_plus;
      logic        space_sign;
      logic        left_justify;
      logic        lower_case;
      logic        alt_prefix;
   } fmt_word_type;

   typedef struct {
      logic [7:0] char_code;
      logic       last;
   } fmt_char_type;

   // ---------------------------------------------------------------------------
   // Clock, reset, DUT ports. Every input starts at a known value.
   // ---------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_value        = '0;
   logic [1:0]  req_radix_select = '0;
   logic [5:0]  req_field_width  = '0;
   logic [5:0]  req_min_digits   = '0;
   logic        req_zero_pad     = 1'b0;
   logic        req_signed_mode  = 1'b0;
   logic        req_show_plus    = 1'b0;
   logic        req_space_sign   = 1'b0;
   logic        req_left_justify = 1'b0;
   logic        req_lower_case   = 1'b0;
   logic        req_alt_prefix   = 1'b0;
   logic        rsp_valid;
   logic [7:0]  rsp_char_code;
   logic        rsp_last;

   always #4ns clock = ~clock;

   integer_to_ascii_formatter_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_radix_select (req_radix_select),
      .req_field_width  (req_field_width),
      .req_min_digits   (req_min_digits),
      .req_zero_pad     (req_zero_pad),
      .req_signed_mode  (req_signed_mode),
      .req_show_plus    (req_show_plus),
      .req_space_sign   (req_space_sign),
      .req_left_justify (req_left_justify),
      .req_lower_case   (req_lower_case),
      .req_alt_prefix   (req_alt_prefix),
      .rsp_valid        (rsp_valid),
      .rsp_char_code    (rsp_char_code),
      .rsp_last         (rsp_last)
   );

   // ---------------------------------------------------------------------------
   // Testbench state
   // ---------------------------------------------------------------------------
   fmt_word_type pending_words[$];     // filled by the stimulus, drained by the driver
   fmt_char_type expected_chars[$];    // formatted text still to come out
   fmt_word_type word_on_bus;          // what the req_* ports currently carry
   int           sender_idle_pct = 11;
   int           error_count     = 0;
   int           stall_cycles    = 0;

   // ---------------------------------------------------------------------------
   // Formatter model: lays out the text of one word and queues each character.
   // Order: lead spaces, sign, prefix, zero pad, precision zeros, digits, trail.
   // ---------------------------------------------------------------------------
   function automatic void queue_formatted_text(input fmt_word_type w);
      int unsigned  base;
      logic [31:0]  mag;
      logic [7:0]   case_or;
      logic [7:0]   sign_char;
      logic [7:0]   digit_lsb_first[$];
      logic [7:0]   text[$];
      logic [3:0]   nib;
      bit           has_sign;
      bit           zpad;
      int           width;
      int           prec;
      int           pfx_len;
      int           slack;
      fmt_char_type c;

      base     = (w.radix == RADIX_OCT) ? 8 : (w.radix == RADIX_DEC) ? 10 : 16;
      width    = (w.width  > MAX_FIELD) ? MAX_FIELD : int'(w.width);
      prec     = (w.digits > MAX_FIELD) ? MAX_FIELD : int'(w.digits);
      zpad     = w.zero_pad && !w.left_justify;     // left justify wins
      case_or  = w.lower_case ? CASE_BIT : 8'h00;
      mag      = w.value;
      has_sign = 1'b0;
      sign_char = ASCII_SPACE;

      // sign flags mean nothing outside signed mode
      if (w.signed_mode) begin
         if (w.value[31]) begin
            has_sign  = 1'b1;
            sign_char = ASCII_MINUS;
            mag       = -w.value;                  // 0x80000000 stays 2147483648
         end else if (w.show_plus) begin
            has_sign  = 1'b1;
            sign_char = ASCII_PLUS;
         end else if (w.space_sign) begin
            has_sign  = 1'b1;
            sign_char = ASCII_SPACE;
         end
      end

      pfx_len = !w.alt_prefix ? 0 : (base == 16) ? 2 : (base == 8) ? 1 : 0;

      // at least one digit, so zero prints '0'
      do begin
         nib = 4'(mag % base);
         digit_lsb_first.push_back(((nib < 10) ? ASCII_ZERO + 8'(nib)
                                               : ASCII_A + 8'(nib - 10)) | case_or);
         mag = mag / base;
      end while (mag != 0);

      if (prec < digit_lsb_first.size()) prec = digit_lsb_first.size();
      slack = width - (has_sign ? 1 : 0) - pfx_len - prec;

      if (!zpad && !w.left_justify)
         for (; slack > 0; slack--) text.push_back(ASCII_SPACE);
      if (has_sign) text.push_back(sign_char);
      if (pfx_len >= 1) text.push_back(ASCII_ZERO);
      if (pfx_len == 2) text.push_back(ASCII_X | case_or);
      if (!w.left_justify)
         for (; slack > 0; slack--) text.push_back(ASCII_ZERO);
      for (int i = digit_lsb_first.size(); i < prec; i++) text.push_back(ASCII_ZERO);
      for (int i = digit_lsb_first.size() - 1; i >= 0; i--)
         text.push_back(digit_lsb_first[i]);
      for (; slack > 0; slack--) text.push_back(ASCII_SPACE);

      foreach (text[i]) begin
         c.char_code = text[i];
         c.last      = (i == text.size() - 1);
         expected_chars.push_back(c);
      end
   endfunction

   function automatic fmt_word_type make_word(input logic [31:0] v, input logic [1:0] r,
                                              input int w, input int d,
                                              input logic [6:0] fl);
      fmt_word_type x;
      x.value  = v;
      x.radix  = r;
      x.width  = 6'(w);
      x.digits = 6'(d);
      {x.zero_pad, x.signed_mode, x.show_plus, x.space_sign,
       x.left_justify, x.lower_case, x.alt_prefix} = fl;
      return x;
   endfunction

   // Mostly short fields with a mix of value shapes; now and then the full
   // 6-bit range so saturation above MAX_FIELD keeps getting hit.
   function automatic fmt_word_type random_format_word();
      logic [31:0] v;
      int          w;
      int          d;
      case ($urandom_range(9))
         5, 6:    v = $urandom_range(99);
         7:       v = -$urandom_range(99);
         8: begin
            case ($urandom_range(3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'hFFFF_FFFF;
               default: v = 32'h0;
            endcase
         end
         9:       v = 32'h1 << $urandom_range(31);
         default: v = $urandom;
      endcase
      w = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(16);
      d = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(12);
      return make_word(v, 2'($urandom_range(3)), w, d, 7'($urandom_range(127)));
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: a word is taken at the edge where start && !busy. The model runs on
   // the word at that same edge; the next word (or an idle) goes out with one
   // nonblocking write per signal so start stays high across back-to-back words.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) queue_formatted_text(word_on_bus);
         if (!start || !busy) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               word_on_bus       = pending_words.pop_front();
               start            <= 1'b1;
               req_value        <= word_on_bus.value;
               req_radix_select <= word_on_bus.radix;
               req_field_width  <= word_on_bus.width;
               req_min_digits   <= word_on_bus.digits;
               req_zero_pad     <= word_on_bus.zero_pad;
               req_signed_mode  <= word_on_bus.signed_mode;
               req_show_plus    <= word_on_bus.show_plus;
               req_space_sign   <= word_on_bus.space_sign;
               req_left_justify <= word_on_bus.left_justify;
               req_lower_case   <= word_on_bus.lower_case;
               req_alt_prefix   <= word_on_bus.alt_prefix;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: every strobed character is matched against the oldest expected one.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      fmt_char_type exp_c;
      if (!reset && rsp_valid) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected character 0x%02h last=%0b", rsp_char_code, rsp_last);
            error_count++;
         end else begin
            exp_c = expected_chars.pop_front();
            if (rsp_char_code !== exp_c.char_code) begin
               $error("char_code: expected 0x%02h, got 0x%02h",
                      exp_c.char_code, rsp_char_code);
               error_count++;
            end
            if (rsp_last !== exp_c.last) begin
               $error("last: expected %0b, got %0b", exp_c.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Watchdog: cycles with neither a word taken nor an awaited character out.
   always @(posedge clock) begin
      if (reset || (start && !busy) || (rsp_valid && expected_chars.size() != 0))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus sequence. Queue traffic happens on the falling edge, away from
   // the driver's rising-edge activity.
   // ---------------------------------------------------------------------------
   task automatic wait_all_taken();
      do @(negedge clock); while (pending_words.size() != 0 || start);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corner cases
      pending_words.push_back(make_word(32'h0, RADIX_DEC, 0, 0, FL_NONE));  // bare zero
      pending_words.push_back(make_word(32'h0, RADIX_OCT, 0, 0, FL_ALT));   // "00"
      pending_words.push_back(make_word(32'h0, RADIX_HEX, 0, 0, FL_ALT));   // "0X0"
      pending_words.push_back(make_word(32'h0, RADIX_HEX, 0, 0, FL_ALT | FL_LC));
      pending_words.push_back(make_word(32'h8000_0000, RADIX_DEC, 0, 0, FL_SGN));
      pending_words.push_back(make_word(32'h8000_0000, RADIX_HEX, 0, 0, FL_SGN | FL_ALT));
      pending_words.push_back(make_word(32'hFFFF_FFFF, RADIX_OCT, 0, 0, FL_NONE));
      pending_words.push_back(make_word(32'hFFFF_FFFF, RADIX_DEC, 0, 0, FL_NONE));
      pending_words.push_back(make_word(32'hFFFF_FFFF, RADIX_HEX, 0, 0, FL_LC));
      pending_words.push_back(make_word(32'hABCD_EF01, RADIX_RSVD, 8, 0, FL_ALT));
      // width and digits past MAX_FIELD saturate
      pending_words.push_back(make_word(32'h7FFF_FFFF, RADIX_DEC, 63, 63,
                                        FL_SGN | FL_PLUS));
      pending_words.push_back(make_word(32'd123, RADIX_DEC, 63, 0, FL_LEFT | FL_ZPAD));
      pending_words.push_back(make_word(32'd42, RADIX_DEC, 10, 0, FL_SGN | FL_PLUS));
      pending_words.push_back(make_word(32'd42, RADIX_DEC, 10, 0, FL_SGN | FL_SPC));
      // sign flags ignored when unsigned
      pending_words.push_back(make_word(32'd42, RADIX_DEC, 10, 0, FL_PLUS | FL_SPC));
      // zero pad and precision zeros together
      pending_words.push_back(make_word(-32'sd7, RADIX_DEC, 12, 5, FL_SGN | FL_ZPAD));
      pending_words.push_back(make_word(32'h1F, RADIX_HEX, 12, 4,
                                        FL_ALT | FL_ZPAD | FL_LC));
      pending_words.push_back(make_word(32'h1F, RADIX_OCT, 12, 4, FL_ALT | FL_LEFT));
      pending_words.push_back(make_word(32'd5, RADIX_DEC, 61, 62,
                                        FL_LEFT | FL_SGN | FL_SPC));
      pending_words.push_back(make_word(32'h8000_0000, RADIX_OCT, 60, 60,
                                        FL_SGN | FL_LEFT | FL_ALT | FL_PLUS));
      pending_words.push_back(make_word(32'd1, RADIX_DEC, 0, 60, FL_NONE));
      pending_words.push_back(make_word(32'h5555_5555, RADIX_HEX, 1, 1,
                                        FL_ZPAD | FL_SGN | FL_PLUS | FL_SPC |
                                        FL_LC | FL_ALT));
      pending_words.push_back(make_word(32'hAAAA_AAAA, RADIX_OCT, 3, 2, 7'h7F));

      // random traffic in three pacing phases: light gaps, heavy gaps, none
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 74 : 0;
         for (int i = 0; i < RANDOM_WORDS / 3; i++)
            pending_words.push_back(random_format_word());
         wait_all_taken();
      end

      // drain, then give any stray character time to show up
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) $display("RESULT: OK");
      else                  $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/iaf_pkg.sv
hw/rtl/integer_to_ascii_formatter_core.sv
verif/tb.sv
